/* src/tvw_pkg.sv */
// Shared constants, codes and types of the triangle vertex welding block.
`default_nettype none

package tvw_pkg;

	// default geometry
	localparam int VERTEX_DEPTH_DEF = 1024;
	localparam int COORD_WIDTH_DEF  = 32;

	// fixed field widths
	localparam int TOL_W      = 16;
	localparam int IDX_OUT_W  = 10;
	localparam int OUTCOME_W  = 2;
	localparam int FACE_W     = 20;
	localparam logic [FACE_W-1:0] FACE_MAX = {FACE_W{1'b1}};

	// APB register map: one 32-bit register per word
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MATCH_TOL = 1'b0;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	// result outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ADDED = 2'd0,
		OUT_DEGEN = 2'd1,
		OUT_FULL  = 2'd2
	} outcome_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DECIDE,
		ST_WRITE,
		ST_FINISH
	} state_t;

	// per-lane control from the sequencer
	typedef struct packed {
		logic clear;
		logic probe;
		logic load;
	} lane_ctl_t;

endpackage

`default_nettype wire

/* src/tvw_in_if.sv */
// Triangle input channel: valid/ready plus the nine corner coordinates.
`default_nettype none

interface tvw_in_if #(
	parameter int COORD_WIDTH = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] first_z;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;
	logic signed [COORD_WIDTH-1:0] second_z;
	logic signed [COORD_WIDTH-1:0] third_x;
	logic signed [COORD_WIDTH-1:0] third_y;
	logic signed [COORD_WIDTH-1:0] third_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		       third_x, third_y, third_z,
		input  ready
	);

	modport sink (
		input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
		       third_x, third_y, third_z,
		output ready
	);
endinterface

`default_nettype wire

/* src/tvw_out_if.sv */
// Result channel: valid/ready plus three indices, outcome and face number.
`default_nettype none

interface tvw_out_if
	import tvw_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] first_index;
	logic [IDX_OUT_W-1:0] second_index;
	logic [IDX_OUT_W-1:0] third_index;
	logic [OUTCOME_W-1:0] outcome;
	logic [FACE_W-1:0]    face_number;

	modport source (
		output valid, first_index, second_index, third_index, outcome, face_number,
		input  ready
	);

	modport sink (
		input  valid, first_index, second_index, third_index, outcome, face_number,
		output ready
	);
endinterface

`default_nettype wire

/* src/tvw_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module tvw_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/tvw_cmp.sv */
// Vertex match: every axis differs by strictly less than the tolerance.
`default_nettype none

module tvw_cmp
	import tvw_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic [3*COORD_WIDTH-1:0] vtx_a,
	input  wire logic [3*COORD_WIDTH-1:0] vtx_b,
	input  wire logic [TOL_W-1:0]         tol,
	output logic                          match
);

	// difference width covers both the coordinate span and the tolerance
	localparam int DW = (COORD_WIDTH + 1 > TOL_W + 1) ? COORD_WIDTH + 1 : TOL_W + 1;

	logic [2:0]           close;
	logic signed [DW-1:0] tol_x;

	assign tol_x = $signed(DW'(tol));

	// one subtract and a window compare per axis
	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [COORD_WIDTH-1:0] a_ax;
		logic signed [COORD_WIDTH-1:0] b_ax;
		logic signed [DW-1:0]          diff;

		assign a_ax    = vtx_a[k*COORD_WIDTH +: COORD_WIDTH];
		assign b_ax    = vtx_b[k*COORD_WIDTH +: COORD_WIDTH];
		assign diff    = DW'(a_ax) - DW'(b_ax);
		assign close[k] = (diff < tol_x) && (diff > -tol_x);
	end

	assign match = &close;

endmodule

`default_nettype wire

/* src/tvw_lane.sv */
// Lookup lane: compares one corner with each streamed table entry, keeps first hit.
`default_nettype none

module tvw_lane
	import tvw_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lane_ctl_t                       ctl,
	input  wire logic [3*COORD_WIDTH-1:0]        corner,
	input  wire logic [3*COORD_WIDTH-1:0]        entry,
	input  wire logic [$clog2(VERTEX_DEPTH)-1:0] idx_in,
	input  wire logic [TOL_W-1:0]                tol,
	output logic                                 found,
	output logic [$clog2(VERTEX_DEPTH)-1:0]      idx
);

	localparam int IDX_W = $clog2(VERTEX_DEPTH);

	logic             hit;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;

	tvw_cmp #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_cmp (
		.vtx_a (entry),
		.vtx_b (corner),
		.tol   (tol),
		.match (hit)
	);

	// first matching entry wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.probe && hit) begin
			found_q <= 1'b1;
		end
	end

	// index: scan hit, or slot given on append
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			idx_q <= '0;
		end else if (ctl.probe && hit && !found_q) begin
			idx_q <= idx_in;
		end else if (ctl.load) begin
			idx_q <= idx_in;
		end
	end

	assign found = found_q;
	assign idx   = idx_q;

endmodule

`default_nettype wire

/* src/triangle_vertex_welding.sv */
// Triangle vertex welding indexer: top level with sequencer, table and lanes.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  triangle  | in  | valid/ready        | first..third_x/y/z, signed COORD_WIDTH
//  result    | out | valid/ready        | three indices, outcome, face_number
//  apb       | in  | psel/penable/pready| match_tolerance at byte address 0
//
//  From a transfer in to its result: one pair check, a sweep of every stored vertex through
//  the single registered read port of the table, one fit decision, three append slots and
//  one result load, and the next triangle is taken in the cycle after the load. A full table
//  skips the append slots; a degenerate triangle goes from the pair check straight to the
//  result load.
//  Reset zeroes vertex and face counts and sets the tolerance to 1; the table is not cleared.
//  A waiting result holds the next triangle in its last step, with the input closed.
`default_nettype none

module triangle_vertex_welding
	import tvw_pkg::*;
#(
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	tvw_in_if.sink                     triangle,
	tvw_out_if.source                  result
);

	localparam int VW    = 3 * COORD_WIDTH;
	localparam int IDX_W = $clog2(VERTEX_DEPTH);
	localparam int CNT_W = $clog2(VERTEX_DEPTH + 1);
	localparam int IXW   = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

	state_t            state_q, state_d;
	logic [VW-1:0]     crn_q [3];
	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  vcount_q;
	logic [FACE_W-1:0] face_q;
	logic [CNT_W-1:0]  iss_q;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	logic [1:0]        wc_q;
	outcome_t          kind_q;

	logic              out_valid_q;
	logic [IDX_OUT_W-1:0] out_idx_q [3];
	outcome_t          out_kind_q;
	logic [FACE_W-1:0] out_face_q;

	logic              accept;
	logic              in_rdy;
	logic              load_out;
	logic [2:0]        pair_hit;
	logic              degen;
	logic              scan_done;
	logic [1:0]        fresh;
	logic [CNT_W:0]    need;
	logic              full;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [VW-1:0]     ram_wdata, ram_rdata;

	lane_ctl_t         lctl [3];
	logic [IDX_W-1:0]  lane_idx_in;
	logic              found [3];
	logic [IDX_W-1:0]  lane_idx [3];
	logic [IXW-1:0]    idx_ext [3];

	// APB register port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == REG_MATCH_TOL) begin
			prdata = APB_DATA_W'(tol_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[APB_ADDR_W-1:2] == REG_MATCH_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// input transfer and corner capture
	assign triangle.ready = in_rdy;
	assign accept         = triangle.valid && in_rdy;

	always_ff @(posedge clk) begin
		if (accept) begin
			crn_q[0] <= {triangle.first_z,  triangle.first_y,  triangle.first_x};
			crn_q[1] <= {triangle.second_z, triangle.second_y, triangle.second_x};
			crn_q[2] <= {triangle.third_z,  triangle.third_y,  triangle.third_x};
		end
	end

	// pairwise degenerate check
	tvw_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_pair01 (
		.vtx_a (crn_q[0]), .vtx_b (crn_q[1]), .tol (tol_q), .match (pair_hit[0])
	);
	tvw_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_pair12 (
		.vtx_a (crn_q[1]), .vtx_b (crn_q[2]), .tol (tol_q), .match (pair_hit[1])
	);
	tvw_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_pair02 (
		.vtx_a (crn_q[0]), .vtx_b (crn_q[2]), .tol (tol_q), .match (pair_hit[2])
	);
	assign degen = |pair_hit;

	// vertex table
	tvw_ram #(
		.WIDTH (VW),
		.DEPTH (VERTEX_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one lookup lane per corner
	assign lane_idx_in = (state_q == ST_WRITE) ? vcount_q[IDX_W-1:0] : rd_addr_s1;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		tvw_lane #(
			.COORD_WIDTH  (COORD_WIDTH),
			.VERTEX_DEPTH (VERTEX_DEPTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl[c]),
			.corner (crn_q[c]),
			.entry  (ram_rdata),
			.idx_in (lane_idx_in),
			.tol    (tol_q),
			.found  (found[c]),
			.idx    (lane_idx[c])
		);
		assign idx_ext[c] = IXW'(lane_idx[c]);
	end

	// merge: unmatched corners and fit check
	assign fresh     = {1'b0, ~found[0]} + {1'b0, ~found[1]} + {1'b0, ~found[2]};
	assign need      = {1'b0, vcount_q} + (CNT_W+1)'(fresh);
	assign full      = need > (CNT_W+1)'(VERTEX_DEPTH);
	assign scan_done = (iss_q == vcount_q) && !rd_v_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = degen ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = full ? ST_FINISH : ST_WRITE;
			end
			ST_WRITE: begin
				if (wc_q == 2'd2) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_rdy    = 1'b0;
		load_out  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = vcount_q[IDX_W-1:0];
		ram_wdata = crn_q[wc_q];
		ram_re    = 1'b0;
		ram_raddr = iss_q[IDX_W-1:0];
		for (int c = 0; c < 3; c++) begin
			lctl[c] = '0;
		end
		unique case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				for (int c = 0; c < 3; c++) begin
					lctl[c].clear = accept;
				end
			end
			ST_SCAN: begin
				ram_re = (iss_q < vcount_q);
				for (int c = 0; c < 3; c++) begin
					lctl[c].probe = rd_v_s1;
				end
			end
			ST_WRITE: begin
				ram_we = !found[wc_q];
				for (int c = 0; c < 3; c++) begin
					lctl[c].load = ram_we && (wc_q == 2'(c));
				end
			end
			ST_FINISH: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vcount_q <= '0;
			face_q   <= '0;
			iss_q    <= '0;
			rd_v_s1  <= 1'b0;
			wc_q     <= '0;
			kind_q   <= OUT_ADDED;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= ram_re;
			if (state_q == ST_CHECK) begin
				iss_q  <= '0;
				kind_q <= degen ? OUT_DEGEN : OUT_ADDED;
			end
			if (ram_re) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (state_q == ST_DECIDE) begin
				wc_q <= '0;
				if (full) kind_q <= OUT_FULL;
			end
			if (state_q == ST_WRITE) begin
				wc_q <= wc_q + 2'd1;
			end
			if (ram_we) begin
				vcount_q <= vcount_q + CNT_W'(1);
			end
			if (load_out && kind_q == OUT_ADDED && face_q != FACE_MAX) begin
				face_q <= face_q + FACE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_raddr;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= kind_q;
			for (int c = 0; c < 3; c++) begin
				out_idx_q[c] <= (kind_q == OUT_ADDED) ? idx_ext[c][IDX_OUT_W-1:0] : '0;
			end
			out_face_q <= (kind_q == OUT_ADDED) ? face_q : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.first_index  = out_idx_q[0];
	assign result.second_index = out_idx_q[1];
	assign result.third_index  = out_idx_q[2];
	assign result.outcome      = out_kind_q;
	assign result.face_number  = out_face_q;

`ifndef ASSERT_OFF
	// table never holds more vertices than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(VERTEX_DEPTH))
		else $error("vertex count beyond table depth");

	// vertex count only moves while appending
	a_count_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(vcount_q) |-> $past(state_q) == ST_WRITE)
		else $error("vertex count changed outside append");

	// an added face only points at stored vertices
	a_idx_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && kind_q == OUT_ADDED) |->
			(CNT_W'(lane_idx[0]) < vcount_q) && (CNT_W'(lane_idx[1]) < vcount_q) &&
			(CNT_W'(lane_idx[2]) < vcount_q))
		else $error("result index outside stored vertices");

	// an accepted triangle always starts with the pair check
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CHECK)
		else $error("accepted triangle skipped pair check");
`endif

endmodule

`default_nettype wire
